>>> sv/dcmet_pkg.sv
`timescale 1ns / 1ps
package dcmet_pkg;

  // Serial multiplier geometry: signed multiplicand, unsigned multiplier
  // consumed one byte per cycle, LSB first.
  localparam int unsigned DigW   = 8;
  localparam int unsigned NumDig = 3;
  localparam int unsigned BW     = DigW * NumDig;
  localparam int unsigned AW     = 41;
  localparam int unsigned PW     = AW + BW;

  typedef logic [2:0]  cfg_idx_t;
  typedef logic [23:0] cfg_data_t;

  // Register map
  localparam cfg_idx_t RegEmfK = 3'd0;
  localparam cfg_idx_t RegCond = 3'd1;
  localparam cfg_idx_t RegRes  = 3'd2;
  localparam cfg_idx_t RegIlim = 3'd3;
  localparam cfg_idx_t RegTto  = 3'd4;
  localparam cfg_idx_t RegDt   = 3'd5;

  typedef struct packed {
    logic [23:0] emf_k;  // V per wheel rad/s, Q8.16
    logic [23:0] cond;   // siemens, Q8.16
    logic [23:0] res;    // ohms, Q8.16
    logic [15:0] ilim;   // amperes, Q8.8
    logic [23:0] tto;    // Nm per ampere, Q8.16
    logic [15:0] dt;     // seconds, Q0.16
  } cfg_t;

endpackage

>>> sv/dcmet_mul.sv
`timescale 1ns / 1ps
// Digit-serial multiplier: one byte of b per cycle, product bits shift
// into the low register as the multiplier digits shift out.
module dcmet_mul (
  input  logic                                  clk_i,
  input  logic                                  rst_ni,
  input  logic                                  start_i,
  input  logic signed [dcmet_pkg::AW-1:0]       a_i,
  input  logic        [dcmet_pkg::BW-1:0]       b_i,
  output logic                                  done_o,
  output logic signed [dcmet_pkg::PW-1:0]       prod_o
);

  localparam int unsigned AW     = dcmet_pkg::AW;
  localparam int unsigned BW     = dcmet_pkg::BW;
  localparam int unsigned DigW   = dcmet_pkg::DigW;
  localparam int unsigned NumDig = dcmet_pkg::NumDig;
  localparam int unsigned SumW   = AW + DigW + 1;
  localparam int unsigned CntW   = $clog2(NumDig);
  localparam logic [CntW-1:0] CntLast = CntW'(NumDig - 1);

  logic signed [AW-1:0]   a_q;
  logic signed [AW-1:0]   hi_q, hi_d;
  logic        [BW-1:0]   lo_q, lo_d;
  logic        [CntW-1:0] cnt_q, cnt_d;
  logic                   busy_q, busy_d;
  logic                   done_q, done_d;
  logic signed [SumW-1:0] pp;
  logic signed [SumW-1:0] sum;

  always_comb begin
    pp   = a_q * $signed({1'b0, lo_q[DigW-1:0]});
    sum  = pp + hi_q;
    hi_d = sum[SumW-2:DigW];
    lo_d = {sum[DigW-1:0], lo_q[BW-1:DigW]};
  end

  always_comb begin
    busy_d = busy_q;
    cnt_d  = cnt_q;
    done_d = 1'b0;
    if (start_i) begin
      busy_d = 1'b1;
      cnt_d  = '0;
    end else if (busy_q) begin
      cnt_d = cnt_q + 1'b1;
      if (cnt_q == CntLast) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      cnt_q  <= '0;
      done_q <= 1'b0;
    end else begin
      busy_q <= busy_d;
      cnt_q  <= cnt_d;
      done_q <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      a_q  <= a_i;
      hi_q <= '0;
      lo_q <= b_i;
    end else if (busy_q) begin
      hi_q <= hi_d;
      lo_q <= lo_d;
    end
  end

  assign done_o = done_q;
  assign prod_o = {hi_q, lo_q};

endmodule

>>> sv/dcmet_cfg.sv
`timescale 1ns / 1ps
// Configuration register file; unknown indexes are dropped.
module dcmet_cfg (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 cfg_we_i,
  input  dcmet_pkg::cfg_idx_t  cfg_idx_i,
  input  dcmet_pkg::cfg_data_t cfg_data_i,
  output dcmet_pkg::cfg_t      cfg_o
);

  localparam dcmet_pkg::cfg_t CfgReset = '{
    emf_k: 24'd0,
    cond:  24'd0,
    res:   24'd65536,
    ilim:  16'd0,
    tto:   24'd0,
    dt:    16'd655
  };

  dcmet_pkg::cfg_t cfg_q, cfg_d;

  always_comb begin
    cfg_d = cfg_q;
    if (cfg_we_i) begin
      unique case (cfg_idx_i)
        dcmet_pkg::RegEmfK: cfg_d.emf_k = cfg_data_i;
        dcmet_pkg::RegCond: cfg_d.cond  = cfg_data_i;
        dcmet_pkg::RegRes:  cfg_d.res   = cfg_data_i;
        dcmet_pkg::RegIlim: cfg_d.ilim  = cfg_data_i[15:0];
        dcmet_pkg::RegTto:  cfg_d.tto   = cfg_data_i;
        dcmet_pkg::RegDt:   cfg_d.dt    = cfg_data_i[15:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q <= CfgReset;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign cfg_o = cfg_q;

endmodule

>>> sv/dc_motor_electrical_thermal_step.sv
`timescale 1ns / 1ps
// Channel   Direction  Handshake                 Payload
// input     in         in_valid_i / in_stall_o   wheel_speed_i, motor_command_i,
//                                                supply_voltage_i
// result    out        out_valid_o / out_stall_i emf_volts_o, motor_current_o,
//                                                shaft_torque_o, wheel_rpm_o,
//                                                temperature_o
// config    in         cfg_we_i (no wait)        cfg_idx_i, cfg_data_i
//
// An item runs from its transfer through the accept cycle, twelve products
// through the shared byte-serial multiplier (operand load, three digits and
// write-back each) and the finish cycle; no new item is taken before idle.
// The result register is loaded in the finish cycle, after the last write-back.
// Reset is asynchronous, active low; winding temperature resets to 25 C.
// A result that is held by out_stall_i keeps the next item in its finish cycle.
module dc_motor_electrical_thermal_step (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  // input channel
  input  logic                 in_valid_i,
  output logic                 in_stall_o,
  input  logic signed [20:0]   wheel_speed_i,
  input  logic signed [15:0]   motor_command_i,
  input  logic        [15:0]   supply_voltage_i,
  // result channel
  output logic                 out_valid_o,
  input  logic                 out_stall_i,
  output logic signed [15:0]   emf_volts_o,
  output logic signed [16:0]   motor_current_o,
  output logic signed [23:0]   shaft_torque_o,
  output logic signed [18:0]   wheel_rpm_o,
  output logic        [15:0]   temperature_o,
  // configuration
  input  logic                 cfg_we_i,
  input  dcmet_pkg::cfg_idx_t  cfg_idx_i,
  input  dcmet_pkg::cfg_data_t cfg_data_i
);

  localparam logic [15:0] TempMin  = 16'd6400;   // 25 C in Q8.8
  localparam logic [15:0] TempMax  = 16'd38400;  // 150 C in Q8.8
  localparam logic [23:0] RpmScale = 24'd9778;   // 1/0.10472 scaled to Q.4 rpm
  localparam logic [23:0] Frac002  = 24'd1311;   // 0.02 in Q.16

  // sequencer states
  localparam logic [1:0] SIdle = 2'd0;
  localparam logic [1:0] SLoad = 2'd1;
  localparam logic [1:0] SRun  = 2'd2;
  localparam logic [1:0] SFin  = 2'd3;

  // product schedule, in order
  localparam logic [3:0] OpEmf   = 4'd0;   // ws * emf_k
  localparam logic [3:0] OpDrive = 4'd1;   // cmd * vbat
  localparam logic [3:0] OpRpm   = 4'd2;   // ws * rpm scale
  localparam logic [3:0] OpCur   = 4'd3;   // diff * conductance
  localparam logic [3:0] OpTlim  = 4'd4;   // ilim * tto
  localparam logic [3:0] OpTorq  = 4'd5;   // cur * tto
  localparam logic [3:0] OpCx    = 4'd6;   // (T - 25C) * dt
  localparam logic [3:0] OpCool  = 4'd7;   // * 0.02
  localparam logic [3:0] OpIsq   = 4'd8;   // |I| * |I|
  localparam logic [3:0] OpHb    = 4'd9;   // * R
  localparam logic [3:0] OpHc    = 4'd10;  // * dt
  localparam logic [3:0] OpHeat  = 4'd11;  // * 0.02

  dcmet_pkg::cfg_t cfg;

  logic [1:0] state_q, state_d;
  logic [3:0] op_q, op_d;
  logic       in_acc;
  logic       mul_start, mul_done, wb_en, fin, out_free;
  logic       out_valid_q, out_valid_d;

  logic signed [dcmet_pkg::AW-1:0] mul_a;
  logic        [dcmet_pkg::BW-1:0] mul_b;
  logic signed [dcmet_pkg::PW-1:0] prod;

  // captured input item
  logic signed [20:0] ws_q;
  logic signed [15:0] cmd_q;
  logic        [15:0] vbat_q;

  // intermediates
  logic signed [44:0] emf26_q;
  logic signed [15:0] emf_q;
  logic signed [40:0] ch_q;       // shared chain: diff, cx, isq, hb, hc
  logic signed [16:0] cur_q;
  logic        [32:0] tlim_q;
  logic signed [23:0] tq_q;
  logic signed [18:0] rpm_q;
  logic        [33:0] cool_q;
  logic signed [51:0] net_q;
  logic        [15:0] temp_q, temp_d;

  // result register
  logic signed [15:0] bemf_out_q;
  logic signed [16:0] cur_out_q;
  logic signed [23:0] tq_out_q;
  logic signed [18:0] rpm_out_q;

  // write-back arithmetic
  logic signed [27:0] emf_rnd;
  logic signed [15:0] emf_sat;
  logic signed [46:0] drive_x;
  logic        [19:0] rpm_rnd;
  logic signed [37:0] cur_rnd;
  logic signed [37:0] ilim_s;
  logic        [16:0] ilim17;
  logic        [16:0] ilim_neg;
  logic signed [16:0] cur_clamp;
  logic        [32:0] tlim_rnd;
  logic signed [34:0] tq_rnd;
  logic signed [34:0] tlim_s;
  logic signed [34:0] tq_lim;
  logic signed [23:0] tq_sat;
  logic signed [51:0] net_new;
  logic signed [16:0] cur_neg;
  logic        [15:0] cur_mag;
  logic        [15:0] temp_rise;
  logic signed [28:0] temp_sum;

  dcmet_cfg u_cfg (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i),
    .cfg_o      (cfg)
  );

  dcmet_mul u_mul (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (mul_start),
    .a_i     (mul_a),
    .b_i     (mul_b),
    .done_o  (mul_done),
    .prod_o  (prod)
  );

  // ---------------------------------------------------------------------------
  // Sequencer
  // ---------------------------------------------------------------------------
  assign in_stall_o = (state_q != SIdle);
  assign in_acc     = in_valid_i && !in_stall_o;
  assign out_free   = !out_valid_q || !out_stall_i;

  always_comb begin
    state_d   = state_q;
    op_d      = op_q;
    mul_start = 1'b0;
    wb_en     = 1'b0;
    fin       = 1'b0;
    unique case (state_q)
      SIdle: begin
        if (in_acc) begin
          state_d = SLoad;
          op_d    = OpEmf;
        end
      end
      SLoad: begin
        mul_start = 1'b1;
        state_d   = SRun;
      end
      SRun: begin
        if (mul_done) begin
          wb_en = 1'b1;
          if (op_q == OpHeat) begin
            state_d = SFin;
          end else begin
            op_d    = op_q + 4'd1;
            state_d = SLoad;
          end
        end
      end
      SFin: begin
        // temperature and result register update together
        if (out_free) begin
          fin     = 1'b1;
          state_d = SIdle;
        end
      end
      default: state_d = SIdle;
    endcase
  end

  // ---------------------------------------------------------------------------
  // Operand select for the shared multiplier (b is always unsigned)
  // ---------------------------------------------------------------------------
  always_comb begin
    cur_neg   = -cur_q;
    cur_mag   = cur_q[16] ? cur_neg[15:0] : cur_q[15:0];
    temp_rise = temp_q - TempMin;  // never negative, temp is clamped
  end

  always_comb begin
    unique case (op_q)
      OpEmf: begin
        mul_a = {{20{ws_q[20]}}, ws_q};
        mul_b = cfg.emf_k;
      end
      OpDrive: begin
        mul_a = {{25{cmd_q[15]}}, cmd_q};
        mul_b = {8'd0, vbat_q};
      end
      OpRpm: begin
        mul_a = {{20{ws_q[20]}}, ws_q};
        mul_b = RpmScale;
      end
      OpCur: begin
        mul_a = ch_q;
        mul_b = cfg.cond;
      end
      OpTlim: begin
        mul_a = {25'd0, cfg.ilim};
        mul_b = cfg.tto;
      end
      OpTorq: begin
        mul_a = {{24{cur_q[16]}}, cur_q};
        mul_b = cfg.tto;
      end
      OpCx: begin
        mul_a = {25'd0, temp_rise};
        mul_b = {8'd0, cfg.dt};
      end
      OpCool: begin
        mul_a = ch_q;
        mul_b = Frac002;
      end
      OpIsq: begin
        mul_a = {25'd0, cur_mag};
        mul_b = {8'd0, cur_mag};
      end
      OpHb: begin
        mul_a = ch_q;
        mul_b = cfg.res;
      end
      OpHc: begin
        mul_a = ch_q;
        mul_b = {8'd0, cfg.dt};
      end
      OpHeat: begin
        mul_a = ch_q;
        mul_b = Frac002;
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  // ---------------------------------------------------------------------------
  // Write-back arithmetic. Rounding to nearest is floor(v >> s) plus bit s-1.
  // ---------------------------------------------------------------------------
  always_comb begin
    // back EMF: Q.26 -> Q8.8, saturate
    emf_rnd = {prod[44], prod[44:18]} + {27'd0, prod[17]};
    if (emf_rnd > 28'sd32767) begin
      emf_sat = 16'sh7FFF;
    end else if (emf_rnd < -28'sd32768) begin
      emf_sat = 16'sh8000;
    end else begin
      emf_sat = emf_rnd[15:0];
    end

    // 2*drive - emf, rounded to Q.16 (unsaturated emf)
    drive_x = {{14{prod[31]}}, prod[31:0], 1'b0}
              - {{2{emf26_q[44]}}, emf26_q} + 47'sd512;

    rpm_rnd = {prod[34], prod[34:16]} + {19'd0, prod[15]};

    // current: Q.32 -> Q8.8, clamp to +-ilim
    cur_rnd  = {prod[60], prod[60:24]} + {37'd0, prod[23]};
    ilim_s   = {22'd0, cfg.ilim};
    ilim17   = {1'b0, cfg.ilim};
    ilim_neg = -ilim17;
    if (cur_rnd > ilim_s) begin
      cur_clamp = ilim17;
    end else if (cur_rnd < -ilim_s) begin
      cur_clamp = ilim_neg;
    end else begin
      cur_clamp = cur_rnd[16:0];
    end

    tlim_rnd = {1'b0, prod[39:8]} + {32'd0, prod[7]};

    // torque: stall clamp, then field saturation
    tq_rnd = {prod[41], prod[41:8]} + {34'd0, prod[7]};
    tlim_s = {2'd0, tlim_q};
    if (tq_rnd > tlim_s) begin
      tq_lim = tlim_s;
    end else if (tq_rnd < -tlim_s) begin
      tq_lim = -tlim_s;
    end else begin
      tq_lim = tq_rnd;
    end
    if (tq_lim > 35'sd8388607) begin
      tq_sat = 24'sh7FFFFF;
    end else if (tq_lim < -35'sd8388608) begin
      tq_sat = 24'sh800000;
    end else begin
      tq_sat = tq_lim[23:0];
    end

    // heat minus cooling, both Q.32
    net_new = {1'b0, prod[50:0]} - {18'd0, cool_q};

    // new temperature
    temp_sum = {13'd0, temp_q} + {net_q[51], net_q[51:24]} + {28'd0, net_q[23]};
    if (temp_sum < 29'sd6400) begin
      temp_d = TempMin;
    end else if (temp_sum > 29'sd38400) begin
      temp_d = TempMax;
    end else begin
      temp_d = temp_sum[15:0];
    end
  end

  // ---------------------------------------------------------------------------
  // Registers
  // ---------------------------------------------------------------------------
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= SIdle;
      op_q        <= OpEmf;
      out_valid_q <= 1'b0;
      temp_q      <= TempMin;
    end else begin
      state_q     <= state_d;
      op_q        <= op_d;
      out_valid_q <= out_valid_d;
      if (fin) begin
        temp_q <= temp_d;
      end
    end
  end

  assign out_valid_d = fin || (out_valid_q && out_stall_i);

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      ws_q   <= wheel_speed_i;
      cmd_q  <= motor_command_i;
      vbat_q <= supply_voltage_i;
    end
    if (wb_en) begin
      unique case (op_q)
        OpEmf: begin
          emf26_q <= prod[44:0];
          emf_q   <= emf_sat;
        end
        OpDrive: ch_q   <= {{4{drive_x[46]}}, drive_x[46:10]};
        OpRpm:   rpm_q  <= rpm_rnd[18:0];
        OpCur:   cur_q  <= cur_clamp;
        OpTlim:  tlim_q <= tlim_rnd;
        OpTorq:  tq_q   <= tq_sat;
        OpCx:    ch_q   <= {9'd0, prod[31:0]};
        OpCool:  cool_q <= prod[41:8];
        OpIsq:   ch_q   <= {9'd0, prod[31:0]};
        OpHb:    ch_q   <= {1'b0, prod[55:16]};
        OpHc:    ch_q   <= {1'b0, prod[55:16]};
        OpHeat:  net_q  <= net_new;
        default: ;
      endcase
    end
    if (fin) begin
      bemf_out_q <= emf_q;
      cur_out_q  <= cur_q;
      tq_out_q   <= tq_q;
      rpm_out_q  <= rpm_q;
    end
  end

  assign out_valid_o     = out_valid_q;
  assign emf_volts_o     = bemf_out_q;
  assign motor_current_o = cur_out_q;
  assign shaft_torque_o  = tq_out_q;
  assign wheel_rpm_o     = rpm_out_q;
  // temperature only moves on a result load, so the state register is the field
  assign temperature_o   = temp_q;

  // ---------------------------------------------------------------------------
  // Assertions
  // ---------------------------------------------------------------------------
  ap_done_in_run: assert property (@(posedge clk_i) disable iff (!rst_ni)
    mul_done |-> state_q == SRun)
    else $error("multiplier finished outside the run state");

  ap_result_from_fin: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_o) |-> $past(state_q == SFin))
    else $error("result appeared without a finish cycle");

  ap_temp_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (temperature_o >= TempMin && temperature_o <= TempMax))
    else $error("temperature out of range");

  ap_cur_limit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> ($signed(motor_current_o) <= $signed({1'b0, cfg.ilim}) &&
                     $signed(motor_current_o) >= -$signed({1'b0, cfg.ilim})))
    else $error("current beyond stall limit");

endmodule
